FILE: sv/tlacc_pkg.sv
// Shared types, widths and the quarter-wave sine table for the arm collision check.
package tlacc_pkg;

   // Trigonometric values are Q1.14 and span -1.0 to +1.0 inclusive.
   localparam int TRIG_W = 16;
   // Register width for a length times a trigonometric value.
   localparam int PROD_W = 32;
   // Rounded Q4.12 link coordinates.
   localparam int COORD_W = 17;
   // A distance component from a sample point to an obstacle centre stays below 32.
   localparam int DIST_W = 18;
   // Rounded Q4.12 square of a distance component.
   localparam int SQ_W = 24;
   // Width of the scaled sample offsets before the bias is added.
   localparam int SAMPLE_W = 40;
   // The scaled sample offsets stay below this power of two in magnitude.
   localparam int BIAS_LOG = 18;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_LINK_LENGTH  = 4'd0,
      CSR_SECOND_LINK_LENGTH = 4'd1,
      CSR_OBSTACLE_A_X       = 4'd2,
      CSR_OBSTACLE_A_Y       = 4'd3,
      CSR_OBSTACLE_B_X       = 4'd4,
      CSR_OBSTACLE_B_Y       = 4'd5,
      CSR_CLEARANCE_SQUARED  = 4'd6,
      CSR_FLOOR_OFFSET       = 4'd7
   } csr_index_type;

   typedef logic signed [TRIG_W-1:0] trig_type;

   localparam trig_type QUARTER_SINE [0:64] = '{
      16'sd0,     16'sd402,   16'sd804,   16'sd1205,  16'sd1606,  16'sd2006,
      16'sd2404,  16'sd2801,  16'sd3196,  16'sd3590,  16'sd3981,  16'sd4370,
      16'sd4756,  16'sd5139,  16'sd5520,  16'sd5897,  16'sd6270,  16'sd6639,
      16'sd7005,  16'sd7366,  16'sd7723,  16'sd8076,  16'sd8423,  16'sd8765,
      16'sd9102,  16'sd9434,  16'sd9760,  16'sd10080, 16'sd10394, 16'sd10702,
      16'sd11003, 16'sd11297, 16'sd11585, 16'sd11866, 16'sd12140, 16'sd12406,
      16'sd12665, 16'sd12916, 16'sd13160, 16'sd13395, 16'sd13623, 16'sd13842,
      16'sd14053, 16'sd14256, 16'sd14449, 16'sd14635, 16'sd14811, 16'sd14978,
      16'sd15137, 16'sd15286, 16'sd15426, 16'sd15557, 16'sd15679, 16'sd15791,
      16'sd15893, 16'sd15986, 16'sd16069, 16'sd16143, 16'sd16207, 16'sd16261,
      16'sd16305, 16'sd16340, 16'sd16364, 16'sd16379, 16'sd16384
   };

   // Sine of a table step, 256 steps to the turn.
   function automatic trig_type sine_step(input logic [7:0] step);
      logic [6:0] idx;
      trig_type   v;
      if (step[6]) begin
         idx = 7'd64 - {1'b0, step[5:0]};
      end else begin
         idx = {1'b0, step[5:0]};
      end
      v = QUARTER_SINE[idx];
      return step[7] ? -v : v;
   endfunction

endpackage

FILE: sv/two_link_arm_collision_check.sv
// Pipelined pose check of a two-link planar arm against the floor and two obstacles.
//
// One transaction enters per clock while req_stall is low, and passes through seven
// register stages (table lookup, link products, rounding and sample scaling,
// reciprocal multiply, distance differences, squaring, final compare) to its
// verdict. A stalled result freezes only the stages behind it that are full, so
// empty stages keep absorbing new transactions until the pipeline is full. The
// division of each sample offset by the sample count is a multiply by a constant
// reciprocal followed by a one-step correction. Configuration writes are always
// taken and must only be issued while the pipeline is empty.
module two_link_arm_collision_check
   import tlacc_pkg::*;
#(
   parameter int ANGLE_BITS   = 16,
   parameter int LINK_SAMPLES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ANGLE_BITS-1:0]  req_shoulder_angle,
   input  logic [ANGLE_BITS-1:0]  req_elbow_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_pose_free,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NS = 7;
   localparam int LS = LINK_SAMPLES;
   // Half of the divisor, added before the floor division of a sample offset.
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_RND = SAMPLE_W'(16384 * LS);
   // Bias that keeps the dividend non-negative; it divides back to 2^BIAS_LOG.
   localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = SAMPLE_W'(LS) << BIAS_LOG;
   localparam int XW = $clog2((LS + 1) * (1 << BIAS_LOG));
   localparam int RS = XW;
   localparam logic [RS:0] RECIP = (RS + 1)'((64'd1 << RS) / LS);
   localparam int RW = XW + 4;
   localparam int TW = SQ_W + 2;

   // Configuration registers.
   logic [14:0]        l1_ff, l2_ff, clr_ff;
   logic signed [15:0] oax_ff, oay_ff, obx_ff, oby_ff, off_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ff  <= 15'd2048;
         l2_ff  <= 15'd1638;
         oax_ff <= -16'sd2458;
         oay_ff <= 16'sd2867;
         obx_ff <= 16'sd2458;
         oby_ff <= 16'sd2867;
         clr_ff <= 15'd256;
         off_ff <= 16'sd410;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FIRST_LINK_LENGTH:  l1_ff  <= csr_wdata[14:0];
            CSR_SECOND_LINK_LENGTH: l2_ff  <= csr_wdata[14:0];
            CSR_OBSTACLE_A_X:       oax_ff <= csr_wdata;
            CSR_OBSTACLE_A_Y:       oay_ff <= csr_wdata;
            CSR_OBSTACLE_B_X:       obx_ff <= csr_wdata;
            CSR_OBSTACLE_B_Y:       oby_ff <= csr_wdata;
            CSR_CLEARANCE_SQUARED:  clr_ff <= csr_wdata[14:0];
            CSR_FLOOR_OFFSET:       off_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage valid bits and per-stage advance enables.
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage 0: table lookups.
   trig_type            s1_ff, c1_ff, s12_ff, c12_ff;
   logic [ANGLE_BITS:0] ang_full;
   logic [7:0]          st1, st12;

   assign ang_full = {1'b0, req_shoulder_angle} + {1'b0, req_elbow_angle};
   assign st1      = req_shoulder_angle[ANGLE_BITS-1 -: 8];
   assign st12     = ang_full[ANGLE_BITS-1 -: 8];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff  <= sine_step(st1);
         c1_ff  <= sine_step(st1 + 8'd64);
         s12_ff <= sine_step(st12);
         c12_ff <= sine_step(st12 + 8'd64);
      end
   end

   // Stage 1: link products.
   logic signed [PROD_W-1:0] pc1_ff, ps1_ff, pc12_ff, ps12_ff;
   logic signed [TRIG_W-1:0] l1s, l2s;

   assign l1s = signed'({1'b0, l1_ff});
   assign l2s = signed'({1'b0, l2_ff});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pc1_ff  <= l1s * c1_ff;
         ps1_ff  <= l1s * s1_ff;
         pc12_ff <= l2s * c12_ff;
         ps12_ff <= l2s * s12_ff;
      end
   end

   // Stage 2: rounding to Q4.12, height test and scaled sample offsets.
   logic signed [COORD_W-1:0] ex2_ff, ey2_ff;
   logic                      hok2_ff;
   logic [XW-1:0]             xx2_ff [LS];
   logic [XW-1:0]             xy2_ff [LS];
   logic signed [COORD_W-1:0] ex2_in, ey2_in;
   logic                      hok2_in;
   logic [XW-1:0]             xx2_in [LS];
   logic [XW-1:0]             xy2_in [LS];

   always_comb begin
      logic signed [PROD_W-1:0]   rx, ry, rt;
      logic signed [COORD_W+1:0]  height;
      logic signed [SAMPLE_W-1:0] sx, sy;
      rx      = (pc1_ff + PROD_W'(8192)) >>> 14;
      ry      = (ps1_ff + PROD_W'(8192)) >>> 14;
      rt      = (ps12_ff + PROD_W'(8192)) >>> 14;
      ex2_in  = rx[COORD_W-1:0];
      ey2_in  = ry[COORD_W-1:0];
      height  = (COORD_W + 2)'(ey2_in) + (COORD_W + 2)'(off_ff);
      hok2_in = (height > 0);
      height  = (COORD_W + 2)'(ey2_in) + (COORD_W + 2)'(signed'(rt[COORD_W-1:0]))
              + (COORD_W + 2)'(off_ff);
      hok2_in = hok2_in && (height > 0);
      for (int i = 0; i < LS; i++) begin
         sx = ((SAMPLE_W'(pc12_ff) * SAMPLE_W'(2 * i + 1)) + SAMPLE_RND) >>> 15;
         sy = ((SAMPLE_W'(ps12_ff) * SAMPLE_W'(2 * i + 1)) + SAMPLE_RND) >>> 15;
         xx2_in[i] = XW'(sx + signed'(SAMPLE_BIAS));
         xy2_in[i] = XW'(sy + signed'(SAMPLE_BIAS));
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ex2_ff  <= ex2_in;
         ey2_ff  <= ey2_in;
         hok2_ff <= hok2_in;
         xx2_ff  <= xx2_in;
         xy2_ff  <= xy2_in;
      end
   end

   // Stage 3: quotient estimate by reciprocal multiply; it is exact or one low.
   logic signed [COORD_W-1:0] ex3_ff, ey3_ff;
   logic                      hok3_ff;
   logic [XW-1:0]             xx3_ff [LS];
   logic [XW-1:0]             xy3_ff [LS];
   logic [XW-1:0]             qx3_ff [LS];
   logic [XW-1:0]             qy3_ff [LS];
   logic [XW-1:0]             qx3_in [LS];
   logic [XW-1:0]             qy3_in [LS];

   always_comb begin
      logic [XW+RS:0] px, py;
      for (int i = 0; i < LS; i++) begin
         px        = (XW + RS + 1)'(xx2_ff[i]) * (XW + RS + 1)'(RECIP);
         py        = (XW + RS + 1)'(xy2_ff[i]) * (XW + RS + 1)'(RECIP);
         qx3_in[i] = px[RS +: XW];
         qy3_in[i] = py[RS +: XW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ex3_ff  <= ex2_ff;
         ey3_ff  <= ey2_ff;
         hok3_ff <= hok2_ff;
         xx3_ff  <= xx2_ff;
         xy3_ff  <= xy2_ff;
         qx3_ff  <= qx3_in;
         qy3_ff  <= qy3_in;
      end
   end

   // Stage 4: quotient correction, sample position and distance components.
   logic                     hok4_ff;
   logic signed [DIST_W-1:0] dx4_ff [LS][2];
   logic signed [DIST_W-1:0] dy4_ff [LS][2];
   logic signed [DIST_W-1:0] dx4_in [LS][2];
   logic signed [DIST_W-1:0] dy4_in [LS][2];

   always_comb begin
      logic [RW-1:0]        remx, remy;
      logic [XW-1:0]        qx, qy;
      logic signed [RW-1:0] offx, offy, posx, posy, dx, dy;
      for (int i = 0; i < LS; i++) begin
         remx = RW'(xx3_ff[i]) - RW'(qx3_ff[i]) * RW'(LS);
         remy = RW'(xy3_ff[i]) - RW'(qy3_ff[i]) * RW'(LS);
         qx   = qx3_ff[i] + XW'(remx >= RW'(LS));
         qy   = qy3_ff[i] + XW'(remy >= RW'(LS));
         offx = signed'(RW'(qx)) - signed'(RW'(1) << BIAS_LOG);
         offy = signed'(RW'(qy)) - signed'(RW'(1) << BIAS_LOG);
         posx = RW'(ex3_ff) + offx;
         posy = RW'(ey3_ff) + offy;
         dx   = posx - RW'(oax_ff);
         dy   = posy - RW'(oay_ff);
         dx4_in[i][0] = dx[DIST_W-1:0];
         dy4_in[i][0] = dy[DIST_W-1:0];
         dx   = posx - RW'(obx_ff);
         dy   = posy - RW'(oby_ff);
         dx4_in[i][1] = dx[DIST_W-1:0];
         dy4_in[i][1] = dy[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         hok4_ff <= hok3_ff;
         dx4_ff  <= dx4_in;
         dy4_ff  <= dy4_in;
      end
   end

   // Stage 5: squares rounded to Q4.12.
   logic            hok5_ff;
   logic [SQ_W-1:0] sqx5_ff [LS][2];
   logic [SQ_W-1:0] sqy5_ff [LS][2];
   logic [SQ_W-1:0] sqx5_in [LS][2];
   logic [SQ_W-1:0] sqy5_in [LS][2];

   always_comb begin
      logic signed [2*DIST_W-1:0] sx, sy;
      for (int i = 0; i < LS; i++) begin
         for (int o = 0; o < 2; o++) begin
            sx = dx4_ff[i][o] * dx4_ff[i][o] + (2 * DIST_W)'(2048);
            sy = dy4_ff[i][o] * dy4_ff[i][o] + (2 * DIST_W)'(2048);
            sqx5_in[i][o] = sx[12 +: SQ_W];
            sqy5_in[i][o] = sy[12 +: SQ_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         hok5_ff <= hok4_ff;
         sqx5_ff <= sqx5_in;
         sqy5_ff <= sqy5_in;
      end
   end

   // Stage 6: clearance compare and output register.
   logic pose_free_ff, pose_free_in;

   always_comb begin
      logic signed [TW-1:0] t;
      pose_free_in = hok5_ff;
      for (int i = 0; i < LS; i++) begin
         for (int o = 0; o < 2; o++) begin
            t = signed'(TW'(sqx5_ff[i][o])) + signed'(TW'(sqy5_ff[i][o]))
              - signed'(TW'(clr_ff));
            if (t <= 0) begin
               pose_free_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         pose_free_ff <= pose_free_in;
      end
   end

   assign rsp_pose_free = pose_free_ff;

   // The input is held off only when every stage holds a transaction.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && ($countones(v_ff) == NS)))
      else $error("input stalled while the pipeline had room");

   // A transaction in the last internal stage moves out when the output is free.
   assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-2] && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("transaction lost between last stage and output");

endmodule

FILE: bench/tlacc_pose_checker.sv
// Watches the arm collision check channels, predicts each pose verdict and compares it.
module tlacc_pose_checker
   import tlacc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [15:0]            req_shoulder_angle,
   input  logic [15:0]            req_elbow_angle,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_pose_free,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     check_failures,
   output int                     verdicts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SAMPLES    = 4;
   localparam longint Q14_ONE    = 16384;
   localparam longint Q12_ONE    = 4096;
   localparam longint SAMPLE_DEN = Q14_ONE * 2 * SAMPLES;

   // Quarter-wave sine in Q1.14, one entry per 1/256 of a turn.
   localparam int ARC_SINE [0:64] = '{
      0, 402, 804, 1205, 1606, 2006, 2404, 2801,
      3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
      6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
      9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
      11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
      13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
      15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
      16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
      16384
   };

   longint first_len;
   longint second_len;
   longint obs_x [0:1];
   longint obs_y [0:1];
   longint clearance_sq;
   longint floor_off;

   bit expected_verdicts [$];
   int mismatches = 0;

   function automatic longint div_round_half_up(input longint num, input longint den);
      longint n2;
      longint d2;
      longint q;
      n2 = 2 * num + den;
      d2 = 2 * den;
      q  = n2 / d2;
      // Division truncates towards zero, so step down for negative remainders.
      if ((n2 % d2) != 0 && n2 < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint sine_of_step(input logic [7:0] step);
      longint v;
      if (step[6]) begin
         v = ARC_SINE[64 - int'(step[5:0])];
      end else begin
         v = ARC_SINE[int'(step[5:0])];
      end
      return step[7] ? -v : v;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_FIRST_LINK_LENGTH:  first_len    = longint'(data[14:0]);
         CSR_SECOND_LINK_LENGTH: second_len   = longint'(data[14:0]);
         CSR_OBSTACLE_A_X:       obs_x[0]     = longint'($signed(data));
         CSR_OBSTACLE_A_Y:       obs_y[0]     = longint'($signed(data));
         CSR_OBSTACLE_B_X:       obs_x[1]     = longint'($signed(data));
         CSR_OBSTACLE_B_Y:       obs_y[1]     = longint'($signed(data));
         CSR_CLEARANCE_SQUARED:  clearance_sq = longint'(data[14:0]);
         CSR_FLOOR_OFFSET:       floor_off    = longint'($signed(data));
         default: ;
      endcase
   endfunction

   function automatic bit predict_pose_free(input logic [15:0] shoulder,
                                            input logic [15:0] elbow);
      logic [15:0] total;
      logic [7:0]  step1;
      logic [7:0]  step12;
      longint      s1, c1, s12, c12;
      longint      ex, ey, tip_y, px, py, dx, dy, margin;
      bit          clear;
      total  = shoulder + elbow;
      step1  = shoulder[15:8];
      step12 = total[15:8];
      s1     = sine_of_step(step1);
      c1     = sine_of_step(step1 + 8'd64);
      s12    = sine_of_step(step12);
      c12    = sine_of_step(step12 + 8'd64);
      ex     = div_round_half_up(first_len * c1, Q14_ONE);
      ey     = div_round_half_up(first_len * s1, Q14_ONE);
      tip_y  = ey + div_round_half_up(second_len * s12, Q14_ONE);
      clear  = (ey + floor_off > 0) && (tip_y + floor_off > 0);
      for (int i = 0; i < SAMPLES; i++) begin
         px = ex + div_round_half_up(second_len * c12 * (2 * i + 1), SAMPLE_DEN);
         py = ey + div_round_half_up(second_len * s12 * (2 * i + 1), SAMPLE_DEN);
         for (int o = 0; o < 2; o++) begin
            dx     = px - obs_x[o];
            dy     = py - obs_y[o];
            margin = div_round_half_up(dx * dx, Q12_ONE)
                     + div_round_half_up(dy * dy, Q12_ONE) - clearance_sq;
            if (margin <= 0) begin
               clear = 1'b0;
            end
         end
      end
      return clear;
   endfunction

   always @(posedge clock) begin
      bit expected;
      if (reset) begin
         first_len    = 2048;
         second_len   = 1638;
         obs_x[0]     = -2458;
         obs_y[0]     = 2867;
         obs_x[1]     = 2458;
         obs_y[1]     = 2867;
         clearance_sq = 256;
         floor_off    = 410;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            store_register(csr_index, csr_wdata);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("pose_free result arrived with no transaction outstanding");
               mismatches++;
            end else begin
               expected = expected_verdicts.pop_front();
               if (rsp_pose_free !== expected) begin
                  $error("pose_free mismatch: expected %0d, actual %0b",
                         expected, rsp_pose_free);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_verdicts = {expected_verdicts,
                                 predict_pose_free(req_shoulder_angle, req_elbow_angle)};
         end
      end
      check_failures   <= mismatches;
      verdicts_pending <= expected_verdicts.size();
   end

endmodule

FILE: bench/tb_two_link_arm_collision_check.sv
// Stimulus, idling and verdict for the two-link arm collision check.
module tb_two_link_arm_collision_check
   import tlacc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT       = 200000;
   localparam int MAX_IDLE          = 13;
   localparam int FIRST_SPARE_INDEX = 8;
   localparam int DRAIN_CYCLES      = 10;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [15:0]            req_shoulder_angle = '0;
   logic [15:0]            req_elbow_angle    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic                   rsp_pose_free;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   int check_failures;
   int verdicts_pending;
   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int cycle_count = 0;

   two_link_arm_collision_check #(
      .ANGLE_BITS   (16),
      .LINK_SAMPLES (4)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_shoulder_angle (req_shoulder_angle),
      .req_elbow_angle    (req_elbow_angle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pose_free      (rsp_pose_free),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   tlacc_pose_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_shoulder_angle (req_shoulder_angle),
      .req_elbow_angle    (req_elbow_angle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pose_free      (rsp_pose_free),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .check_failures     (check_failures),
      .verdicts_pending   (verdicts_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The result side holds off for a fresh random number of cycles before each transaction.
   always begin : result_stall
      int hold;
      hold = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
      if (hold > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (rsp_valid !== 1'b1) @(posedge clock);
   end

   task automatic send_pose(input logic [15:0] shoulder, input logic [15:0] elbow);
      int gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_shoulder_angle <= shoulder;
      req_elbow_angle    <= elbow;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic run_random_poses(input int count);
      repeat (count) begin
         send_pose(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
   endtask

   // Stops the sender and lets the pipeline empty before any register is touched.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_registers(input logic [15:0] l1, input logic [15:0] l2,
                                 input logic [15:0] ax, input logic [15:0] ay,
                                 input logic [15:0] bx, input logic [15:0] by,
                                 input logic [15:0] clr, input logic [15:0] off);
      write_register(CSR_FIRST_LINK_LENGTH, l1);
      write_register(CSR_SECOND_LINK_LENGTH, l2);
      write_register(CSR_OBSTACLE_A_X, ax);
      write_register(CSR_OBSTACLE_A_Y, ay);
      write_register(CSR_OBSTACLE_B_X, bx);
      write_register(CSR_OBSTACLE_B_Y, by);
      write_register(CSR_CLEARANCE_SQUARED, clr);
      write_register(CSR_FLOOR_OFFSET, off);
      // Writes to unused indexes must leave every register alone.
      write_register(CSR_INDEX_W'($urandom_range(FIRST_SPARE_INDEX, 2**CSR_INDEX_W - 1)),
                     16'($urandom_range(0, 65535)));
   endtask

   // Half the time any 16-bit pattern, otherwise a value within a plausible working span.
   function automatic logic [15:0] draw_setting(input int lo, input int hi);
      if ($urandom_range(0, 1) == 1) begin
         return 16'($urandom_range(0, 65535));
      end
      return 16'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, corner angles back to back.
      send_pose(16'h0000, 16'h0000);
      send_pose(16'hFFFF, 16'hFFFF);
      send_pose(16'h4000, 16'h0000);
      send_pose(16'h8000, 16'h0000);
      send_pose(16'hC000, 16'h0000);
      send_pose(16'h0000, 16'h4000);
      send_pose(16'h0000, 16'h8000);
      send_pose(16'h0000, 16'hC000);
      send_pose(16'h00FF, 16'h00FF);
      send_pose(16'h3FFF, 16'h0001);
      send_pose(16'h4000, 16'hC000);
      send_pose(16'h2000, 16'h2000);
      send_pose(16'h6000, 16'hE000);
      send_pose(16'hA000, 16'h4000);
      send_pose(16'hFF00, 16'h0100);
      send_pose(16'h1234, 16'hEDCB);
      send_pose(16'h5555, 16'hAAAA);
      send_pose(16'hAAAA, 16'h5555);
      req_gap_max = MAX_IDLE;
      rsp_gap_max = MAX_IDLE;
      run_random_poses(100);

      // Both links folded to nothing: heights and clearances land exactly on zero.
      wait_drained();
      load_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h1000, 16'h0000, 16'h0000, 16'h0000);
      send_pose(16'h0000, 16'h0000);
      send_pose(16'h4000, 16'h4000);
      wait_drained();
      write_register(CSR_FLOOR_OFFSET, 16'h0001);
      send_pose(16'h0000, 16'h0000);
      send_pose(16'hC000, 16'h8000);
      wait_drained();
      write_register(CSR_OBSTACLE_A_X, 16'h0040);
      send_pose(16'h0000, 16'h0000);
      send_pose(16'h8000, 16'h4000);

      // Largest values, with out-of-range bits on the unsigned registers.
      wait_drained();
      load_registers(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
                     16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000);
      req_gap_max = 0;
      rsp_gap_max = MAX_IDLE;
      run_random_poses(50);

      wait_drained();
      load_registers(16'h0000, 16'h7FFF, 16'h8000, 16'h8000,
                     16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF);
      req_gap_max = MAX_IDLE;
      rsp_gap_max = 0;
      run_random_poses(40);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         load_registers(draw_setting(0, 8192), draw_setting(0, 8192),
                        draw_setting(-8192, 8192), draw_setting(-8192, 8192),
                        draw_setting(-8192, 8192), draw_setting(-8192, 8192),
                        draw_setting(0, 2048), draw_setting(-2048, 2048));
         req_gap_max = p[0] ? MAX_IDLE : 0;
         rsp_gap_max = p[1] ? MAX_IDLE : 0;
         run_random_poses(50);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (check_failures == 0 && verdicts_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
